@@ rtl/tsgd_pkg.sv @@
`timescale 1ns / 1ps

package tsgd_pkg;

  // Coordinate storage width; event values above its range saturate
  localparam int COORD_WIDTH = 16;

  // Fixed field widths of the event and result items
  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 16;
  localparam int GEST_W  = 3;
  localparam int POS_W   = 16;
  localparam int DIST_W  = 16;

  // Width used when comparing axis travel against the swipe threshold
  localparam int CMP_W = (COORD_WIDTH > DIST_W) ? COORD_WIDTH : DIST_W;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS   = TYPE_W + CODE_W + VALUE_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = GEST_W + 2 * POS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Register file
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [0:0] REG_MIN_SWIPE = 1'b0;
  localparam logic [DIST_W-1:0] MIN_SWIPE_RESET = DIST_W'(50);

  // Event decode
  localparam logic [TYPE_W-1:0] EVT_KEY    = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] EVT_ABS    = TYPE_W'(3);
  localparam logic [CODE_W-1:0] CODE_TOUCH = CODE_W'(330);
  localparam logic [CODE_W-1:0] CODE_X     = CODE_W'(0);
  localparam logic [CODE_W-1:0] CODE_Y     = CODE_W'(1);
  localparam logic [VALUE_W-1:0] BTN_PRESS   = VALUE_W'(1);
  localparam logic [VALUE_W-1:0] BTN_RELEASE = VALUE_W'(0);

  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [GEST_W-1:0] {
    G_RIGHT = 3'd0,
    G_LEFT  = 3'd1,
    G_DOWN  = 3'd2,
    G_UP    = 3'd3,
    G_CLICK = 3'd4
  } gesture_t;

  // Clamp an event value to the coordinate range
  localparam int SAT_W = ((COORD_WIDTH > VALUE_W) ? COORD_WIDTH : VALUE_W) + 1;
  localparam logic [SAT_W-1:0] COORD_MAX = (SAT_W'(1) << COORD_WIDTH) - SAT_W'(1);

  function automatic coord_t sat_coord(input logic [VALUE_W-1:0] v);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(v);
    if (ext > COORD_MAX) begin
      return coord_t'(COORD_MAX);
    end
    return coord_t'(ext);
  endfunction

endpackage

@@ rtl/touch_swipe_gesture_detector_core.sv @@
`timescale 1ns / 1ps
// The gesture of an accepted release event is held in the output register, which drives m_tdata.
// Throughput: one event per cycle; the output register stalls input only when it holds
//   an untaken result and the sink is not ready.
// Reset (rst, synchronous, active high): not pressed, current and start points zero,
//   swipe threshold = 50, output empty.

module touch_swipe_gesture_detector_core
  import tsgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // event stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // event_type, event_code, event_value, pad
  // gesture stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // gesture, end_x, end_y, pad
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  // Configuration register
  logic [DIST_W-1:0] swipe_thresh;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_thresh <= MIN_SWIPE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_SWIPE)) begin
      swipe_thresh <= pwdata[DIST_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_SWIPE) begin
      prdata = DATA_W'(swipe_thresh);
    end
  end

  // Input field unpack
  logic [TYPE_W-1:0]  event_type;
  logic [CODE_W-1:0]  event_code;
  logic [VALUE_W-1:0] event_value;

  assign event_type  = s_tdata[TYPE_W-1:0];
  assign event_code  = s_tdata[TYPE_W +: CODE_W];
  assign event_value = s_tdata[TYPE_W+CODE_W +: VALUE_W];

  // Handshake: the output register frees up when its result is taken
  logic in_xfer;
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // Event decode
  logic is_touch, is_press, is_release, is_x, is_y;
  coord_t coord;

  assign is_touch   = (event_type == EVT_KEY) && (event_code == CODE_TOUCH);
  assign is_press   = is_touch && (event_value == BTN_PRESS);
  assign is_release = is_touch && (event_value == BTN_RELEASE);
  assign is_x       = (event_type == EVT_ABS) && (event_code == CODE_X);
  assign is_y       = (event_type == EVT_ABS) && (event_code == CODE_Y);
  assign coord      = sat_coord(event_value);

  // Touch tracking state
  logic   pressed;
  coord_t cur_x, cur_y, start_x, start_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed <= 1'b0;
      cur_x   <= '0;
      cur_y   <= '0;
      start_x <= '0;
      start_y <= '0;
    end else if (in_xfer) begin
      if (is_press) begin
        pressed <= 1'b1;
      end
      if (is_release) begin
        pressed <= 1'b0;
        start_x <= '0;
        start_y <= '0;
      end
      if (is_x) begin
        cur_x <= coord;
        if (pressed && (start_x == '0)) begin
          start_x <= coord;
        end
      end
      if (is_y) begin
        cur_y <= coord;
        if (pressed && (start_y == '0)) begin
          start_y <= coord;
        end
      end
    end
  end

  // Gesture classification from end and start points
  logic signed [COORD_WIDTH:0] dx, dy;
  coord_t   ax, ay;
  logic     is_swipe, dx_pos, dy_pos;
  gesture_t gesture_next;

  assign dx = signed'({1'b0, cur_x}) - signed'({1'b0, start_x});
  assign dy = signed'({1'b0, cur_y}) - signed'({1'b0, start_y});
  // magnitude of a (COORD_WIDTH+1)-bit difference always fits COORD_WIDTH bits
  assign ax = dx[COORD_WIDTH] ? coord_t'(-dx) : coord_t'(dx);
  assign ay = dy[COORD_WIDTH] ? coord_t'(-dy) : coord_t'(dy);
  assign dx_pos = !dx[COORD_WIDTH] && (dx != '0);
  assign dy_pos = !dy[COORD_WIDTH] && (dy != '0);
  assign is_swipe = (CMP_W'(ax) >= CMP_W'(swipe_thresh)) ||
                    (CMP_W'(ay) >= CMP_W'(swipe_thresh));

  always_comb begin
    priority if (!is_swipe) begin
      gesture_next = G_CLICK;
    end else if (ax > ay) begin
      gesture_next = dx_pos ? G_RIGHT : G_LEFT;
    end else begin
      gesture_next = dy_pos ? G_DOWN : G_UP;
    end
  end

  // Output register
  logic [GEST_W-1:0] gesture;
  logic [POS_W-1:0]  end_x, end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= is_release;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_release) begin
      gesture <= gesture_next;
      end_x   <= POS_W'(cur_x);
      end_y   <= POS_W'(cur_y);
    end
  end

  assign m_tdata = OUT_DATA_W'({end_y, end_x, gesture});

endmodule

@@ rtl/tsgd_checker.sv @@
`timescale 1ns / 1ps

module tsgd_checker
  import tsgd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic in_xfer, in_release, out_held;

  assign in_xfer    = s_tvalid && s_tready;
  assign in_release = (s_tdata[TYPE_W-1:0] == EVT_KEY) &&
                      (s_tdata[TYPE_W +: CODE_W] == CODE_TOUCH) &&
                      (s_tdata[TYPE_W+CODE_W +: VALUE_W] == BTN_RELEASE);
  assign out_held   = m_tvalid && !m_tready;

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_held |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Only gesture codes zero to four appear
  a_gesture_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[GEST_W-1:0] <= GEST_W'(G_CLICK)))
    else $error("gesture code out of range");

  // A release transfer yields a result in the next cycle
  a_release_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_release) |=> m_tvalid)
    else $error("release produced no gesture");

  // Other events produce no result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !in_release && !out_held) |=> !m_tvalid)
    else $error("result without a release");

  // Output is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind touch_swipe_gesture_detector_core tsgd_checker u_tsgd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/tb_touch_swipe_gesture_detector_core.sv @@
`timescale 1ns / 1ps

module tb_touch_swipe_gesture_detector_core;
  import tsgd_pkg::*;

  localparam int IDLE_PCT      = 28;
  localparam int MAX_GAP       = 20;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 10;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 160;
  localparam int PRINT_LIMIT   = 30;

  // Events the block must ignore
  localparam logic [TYPE_W-1:0]  TYPE_OTHER      = TYPE_W'(31);
  localparam logic [CODE_W-1:0]  CODE_OTHER      = CODE_W'(767);
  localparam logic [CODE_W-1:0]  CODE_NEAR_TOUCH = CODE_W'(331);
  localparam logic [VALUE_W-1:0] BTN_OTHER       = VALUE_W'(2);

  typedef struct packed {
    gesture_t gest;
    coord_t   ex;
    coord_t   ey;
  } gesture_rec_t;

  typedef enum logic {ROW_EVT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [TYPE_W-1:0]    typ;
    logic [CODE_W-1:0]    code;
    logic [VALUE_W-1:0]   val;
    logic                 typed;
    gesture_rec_t         want;
  } stim_row_t;

  localparam gesture_rec_t NONE_REC = '{G_CLICK, '0, '0};

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_W-1:0]     paddr     = '0;
  logic [DATA_W-1:0]     pwdata    = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  touch_swipe_gesture_detector_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predicted touch state and threshold
  logic              touch_down = 1'b0;
  coord_t            x_now      = '0;
  coord_t            y_now      = '0;
  coord_t            x_start    = '0;
  coord_t            y_start    = '0;
  logic [DIST_W-1:0] swipe_min  = MIN_SWIPE_RESET;

  gesture_rec_t pending_gestures[$];
  gesture_rec_t head;
  int           errors      = 0;
  int           sent_count  = 0;
  int           cfg_writes  = 0;
  int           quiet_cycles = 0;
  int           gest_tally[5] = '{0, 0, 0, 0, 0};
  bit           no_idle     = 1'b0;

  // Directed rows: reset state, extremes, ignored events, zero threshold, max threshold
  stim_row_t dir_rows [26] = '{
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_RELEASE, 1'b1, '{G_CLICK, 16'd0, 16'd0}},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_PRESS, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_X, 16'd100, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_Y, 16'd100, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_X, 16'd300, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_RELEASE, 1'b1, '{G_RIGHT, 16'd300, 16'd100}},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_PRESS, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_X, 16'd0, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_X, 16'hFFFF, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_Y, 16'hFFFF, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_Y, 16'd0, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_OTHER, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_PRESS, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_NEAR_TOUCH, BTN_RELEASE, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_X, BTN_RELEASE, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_TOUCH, 16'd0, 1'b0, NONE_REC},
    '{ROW_EVT, TYPE_OTHER, CODE_OTHER, 16'hFFFF, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_RELEASE, 1'b1, '{G_UP, 16'hFFFF, 16'd0}},
    '{ROW_CFG, '0, '0, 16'd0, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_X, 16'd0, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_Y, 16'd0, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_PRESS, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_RELEASE, 1'b1, '{G_UP, 16'd0, 16'd0}},
    '{ROW_CFG, '0, '0, 16'hFFFF, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_ABS, CODE_X, 16'hFFFF, 1'b0, NONE_REC},
    '{ROW_EVT, EVT_KEY, CODE_TOUCH, BTN_RELEASE, 1'b1, '{G_RIGHT, 16'hFFFF, 16'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Touch tracker: returns 1 with the gesture when the event is a release
  function automatic bit track_touch(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
                                     input logic [VALUE_W-1:0] v, output gesture_rec_t r);
    longint top, clamped, dx, dy, ax, ay;
    top = (longint'(1) << COORD_WIDTH) - 1;
    r = NONE_REC;
    if (t == EVT_KEY && c == CODE_TOUCH) begin
      if (v == BTN_PRESS) begin
        touch_down = 1'b1;
      end else if (v == BTN_RELEASE) begin
        dx = longint'(x_now) - longint'(x_start);
        dy = longint'(y_now) - longint'(y_start);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax >= longint'(swipe_min) || ay >= longint'(swipe_min)) begin
          if (ax > ay) begin
            r.gest = (dx > 0) ? G_RIGHT : G_LEFT;
          end else begin
            r.gest = (dy > 0) ? G_DOWN : G_UP;
          end
        end else begin
          r.gest = G_CLICK;
        end
        r.ex = x_now;
        r.ey = y_now;
        touch_down = 1'b0;
        x_start = '0;
        y_start = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (t == EVT_ABS) begin
      clamped = (longint'(v) > top) ? top : longint'(v);
      if (c == CODE_X) begin
        x_now = coord_t'(clamped);
        if (touch_down && x_start == '0) x_start = coord_t'(clamped);
      end else if (c == CODE_Y) begin
        y_now = coord_t'(clamped);
        if (touch_down && y_start == '0) y_start = coord_t'(clamped);
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("mismatch %0d at %0t ns: %s got %0d expected %0d", errors, $realtime, what,
               got, want);
    end
  endtask

  // One event transfer, with a random gap before it
  task automatic send_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
                            input logic [VALUE_W-1:0] v, input bit use_typed,
                            input gesture_rec_t typed_rec);
    int           gap;
    gesture_rec_t r;
    gap = 0;
    if (!no_idle) begin
      while (gap < MAX_GAP && $urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({v, c, t});
    do @(posedge clk); while (!s_tready);
    sent_count++;
    if (track_touch(t, c, v, r)) begin
      if (use_typed) r = typed_rec;
      gest_tally[r.gest]++;
      pending_gestures.push_back(r);
    end
  endtask

  // Stop sending and wait out every pending gesture
  task automatic drain_gestures(input int settle);
    s_tvalid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_min_swipe(input logic [DIST_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * REG_MIN_SWIPE);
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    swipe_min = v;
    cfg_writes++;
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return coord_t'($urandom_range(1, 255));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // End point placed around the threshold from the start point, or at a random or zero offset
  function automatic coord_t shift_coord(input coord_t base);
    longint d, top, r;
    top = (longint'(1) << COORD_WIDTH) - 1;
    case ($urandom_range(0, 5))
      0: d = longint'(swipe_min);
      1: d = longint'(swipe_min) - 1;
      2: d = longint'(swipe_min) + 1;
      3: d = $urandom_range(0, 300);
      4: d = $urandom_range(0, 65535);
      default: d = 0;
    endcase
    if ($urandom_range(0, 1) != 0) d = -d;
    r = longint'(base) + d;
    if (r < 0) r = 0;
    if (r > top) r = top;
    return coord_t'(r);
  endfunction

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_event(TYPE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 767)),
                    VALUE_W'($urandom), 1'b0, NONE_REC);
      1: send_event(EVT_KEY, CODE_TOUCH, VALUE_W'($urandom_range(0, 3)), 1'b0, NONE_REC);
      2: send_event(EVT_ABS, CODE_W'($urandom_range(0, 3)), pick_coord(), 1'b0, NONE_REC);
      default: send_event(TYPE_W'($urandom_range(0, 4)), CODE_TOUCH,
                          VALUE_W'($urandom_range(0, 1)), 1'b0, NONE_REC);
    endcase
  endtask

  // Press, start point, some moves, end point, release; parts dropped now and then
  task automatic send_stroke();
    coord_t x0, y0;
    int     moves;
    x0 = pick_coord();
    y0 = pick_coord();
    moves = $urandom_range(0, 3);
    if ($urandom_range(0, 19) != 0) send_event(EVT_KEY, CODE_TOUCH, BTN_PRESS, 1'b0, NONE_REC);
    if ($urandom_range(0, 9) != 0) send_event(EVT_ABS, CODE_X, x0, 1'b0, NONE_REC);
    if ($urandom_range(0, 9) != 0) send_event(EVT_ABS, CODE_Y, y0, 1'b0, NONE_REC);
    repeat (moves) begin
      if ($urandom_range(0, 5) == 0) begin
        send_noise();
      end else if ($urandom_range(0, 1) != 0) begin
        send_event(EVT_ABS, CODE_X, pick_coord(), 1'b0, NONE_REC);
      end else begin
        send_event(EVT_ABS, CODE_Y, pick_coord(), 1'b0, NONE_REC);
      end
    end
    if ($urandom_range(0, 9) != 0) send_event(EVT_ABS, CODE_X, shift_coord(x0), 1'b0, NONE_REC);
    if ($urandom_range(0, 9) != 0) send_event(EVT_ABS, CODE_Y, shift_coord(y0), 1'b0, NONE_REC);
    if ($urandom_range(0, 19) != 0) begin
      send_event(EVT_KEY, CODE_TOUCH, BTN_RELEASE, 1'b0, NONE_REC);
    end else begin
      send_noise();
    end
  endtask

  // Gesture sink: random stalls, check each transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_gestures.size() == 0) begin
        report_mismatch("gesture with nothing pending, tdata", longint'(m_tdata), 0);
      end else begin
        head = pending_gestures.pop_front();
        if (m_tdata[GEST_W-1:0] !== head.gest)
          report_mismatch("gesture", longint'(m_tdata[GEST_W-1:0]), longint'(head.gest));
        if (m_tdata[GEST_W +: POS_W] !== head.ex)
          report_mismatch("end_x", longint'(m_tdata[GEST_W +: POS_W]), longint'(head.ex));
        if (m_tdata[GEST_W+POS_W +: POS_W] !== head.ey)
          report_mismatch("end_y", longint'(m_tdata[GEST_W+POS_W +: POS_W]),
                          longint'(head.ey));
      end
    end
    m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d gestures pending", quiet_cycles,
               pending_gestures.size());
      $display("FAIL touch_swipe_gesture_detector_core");
      $finish;
    end
  end

  initial begin
    int               target;
    int               pause_at;
    bit               paused;
    logic [DIST_W-1:0] th;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_gestures(SETTLE_CYCLES);
        write_min_swipe(dir_rows[i].val);
      end else begin
        send_event(dir_rows[i].typ, dir_rows[i].code, dir_rows[i].val, dir_rows[i].typed,
                   dir_rows[i].want);
      end
    end

    // Random phases, one threshold each; phase 2 runs without idling
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: th = '0;
        1: th = '1;
        2: th = DIST_W'(1);
        3: th = DIST_W'($urandom_range(2, 400));
        4: th = DIST_W'($urandom_range(0, 65535));
        default: th = MIN_SWIPE_RESET;
      endcase
      drain_gestures(SETTLE_CYCLES);
      no_idle = (p == 2);
      write_min_swipe(th);
      target   = sent_count + PHASE_ITEMS;
      pause_at = sent_count + PHASE_ITEMS / 2;
      while (sent_count < target) begin
        // hold off the sender until the sink has caught up
        if (p == 3 && !paused && sent_count >= pause_at) begin
          drain_gestures(1);
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          send_stroke();
        end else begin
          send_noise();
        end
      end
    end
    no_idle = 1'b0;

    drain_gestures(END_CYCLES);
    $display("covered %0d events and %0d threshold writes, with 0 and max among them",
             sent_count, cfg_writes);
    $display("gestures: right %0d left %0d down %0d up %0d click %0d", gest_tally[G_RIGHT],
             gest_tally[G_LEFT], gest_tally[G_DOWN], gest_tally[G_UP], gest_tally[G_CLICK]);
    if (errors == 0) begin
      $display("PASS touch_swipe_gesture_detector_core");
    end else begin
      $display("FAIL touch_swipe_gesture_detector_core");
    end
    $finish;
  end

endmodule
